// ----- src/exponential_retention_curve_top_defines.svh -----
// ----------------------------------------------------------------------------
// Exponential retention curve assertion macros
// Shared concurrent assertion forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef EXPONENTIAL_RETENTION_CURVE_TOP_DEFINES_SVH
`define EXPONENTIAL_RETENTION_CURVE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ERC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("retention curve check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ERC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("retention curve check failed: next-cycle implication");

`endif

// ----- src/erc_pkg.sv -----
// ----------------------------------------------------------------------------
// Exponential retention curve package
// Types, status codes, pipeline stage counts and constants for the block.
// ----------------------------------------------------------------------------
package erc_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_COMPUTED = 2'd0,
        ST_DRY      = 2'd1,
        ST_SAT      = 2'd2,
        ST_DEGEN    = 2'd3
    } status_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_DECAY     = 2'd0,
        REG_RESIDUAL  = 2'd1,
        REG_SATURATED = 2'd2,
        REG_DRY_LIMIT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] decay_rate;
        logic [15:0] residual;
        logic [15:0] saturated;
        logic [47:0] dry_limit;
    } cfg_t;

    // Control tag that travels with an item through the log path.
    typedef struct packed {
        logic    valid;
        logic    mode;
        status_t cls;
    } tag_t;

    typedef struct packed {
        logic        valid;
        logic        mode;
        status_t     status;
        logic [47:0] head;
    } ln_result_t;

    typedef struct packed {
        logic [15:0] content;
        status_t     status;
    } exp_result_t;

    // Fixed-point constants.
    localparam logic [31:0] LN2_Q32   = 32'hB172_17F8;
    localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
    localparam logic [38:0] XCAP_Q32  = 39'h40_0000_0000;
    localparam logic [7:0]  SH_BASE   = 8'd30;
    localparam logic [6:0]  N_CAP     = 7'd20;

    // Reset values of the configuration registers.
    localparam logic [31:0] DECAY_RESET     = 32'h0100_0000;
    localparam logic [15:0] RESIDUAL_RESET  = 16'h0000;
    localparam logic [15:0] SATURATED_RESET = 16'hFFFF;
    localparam logic [47:0] DRY_RESET       = 48'hFFF0_BDC0_0000;

    // floor(2^32 / n) for the series divisors; entries 0 and 1 are unused.
    localparam logic [31:0] EXP_RECIP [0:12] = '{
        32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h5555_5555,
        32'h4000_0000, 32'h3333_3333, 32'h2AAA_AAAA, 32'h2492_4924,
        32'h2000_0000, 32'h1C71_C71C, 32'h1999_9999, 32'h1745_D174,
        32'h1555_5555
    };

    // Log path stage plan.
    localparam int QDIV_BITS   = 32;
    localparam int QDIV_STEPS  = 4;
    localparam int QDIV_STAGES = QDIV_BITS / QDIV_STEPS;
    localparam int SQ_STAGES   = 32;
    localparam int HDIV_BITS   = 46;
    localparam int HDIV_STEPS  = 2;
    localparam int HDIV_STAGES = HDIV_BITS / HDIV_STEPS;
    localparam int LN_LAT      = 1 + QDIV_STAGES + 1 + SQ_STAGES + 2 + HDIV_STAGES + 1;

    // Exponential path stage plan.
    localparam int XDIV_STAGES = 7;
    localparam int EXP_TERMS   = 12;
    localparam int EXP_LAT     = 3 + XDIV_STAGES + 1 + 3 * EXP_TERMS + 3;
    localparam int EXP_PAD     = LN_LAT - EXP_LAT;

endpackage

// ----- src/exponential_retention_curve_top.sv -----
// ----------------------------------------------------------------------------
// Exponential retention curve top level
// Converts between water content and pressure head on an exponential
// retention curve, with an APB-style register port for the curve constants.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  item      in         item_valid / item_stall    mode, water_content, pressure_head
//  result    out        result_valid / result_stall head_result, content_result, status
//  config    in         psel / penable / pready    paddr, pwdata, prdata
//
//  One transaction enters per cycle while item_stall is low; result_valid rises
//  once its item has passed the log path tag line and the output register.
//  The log path sets the pipeline depth: ratio division, 32 squaring stages and
//  the 46-bit division by the decay rate, each cut into register stages.
//  A stalled result freezes the whole pipeline, so item_stall follows it.
//  Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module exponential_retention_curve_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        mode,
    input  logic [15:0] water_content,
    input  logic [47:0] pressure_head,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [47:0] head_result,
    output logic [15:0] content_result,
    output logic [1:0]  status
);
    import erc_pkg::*;

    cfg_t        cfg_reg;
    logic        en;
    ln_result_t  ln_res;
    exp_result_t exp_res;
    exp_result_t exp_dly_reg [0:EXP_PAD-1];
    logic        out_valid_reg;
    logic [47:0] head_reg;
    logic [15:0] content_reg;
    status_t     status_reg;
    reg_idx_t    idx;

    assign idx    = reg_idx_t'(paddr[4:3]);
    assign pready = 1'b1;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.decay_rate <= DECAY_RESET;
            cfg_reg.residual   <= RESIDUAL_RESET;
            cfg_reg.saturated  <= SATURATED_RESET;
            cfg_reg.dry_limit  <= DRY_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_DECAY:     cfg_reg.decay_rate <= pwdata[31:0];
                REG_RESIDUAL:  cfg_reg.residual   <= pwdata[15:0];
                REG_SATURATED: cfg_reg.saturated  <= pwdata[15:0];
                REG_DRY_LIMIT: cfg_reg.dry_limit  <= pwdata[47:0];
                default:       cfg_reg.decay_rate <= cfg_reg.decay_rate;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        unique case (idx)
            REG_DECAY:     prdata = {32'd0, cfg_reg.decay_rate};
            REG_RESIDUAL:  prdata = {48'd0, cfg_reg.residual};
            REG_SATURATED: prdata = {48'd0, cfg_reg.saturated};
            REG_DRY_LIMIT: prdata = {16'd0, cfg_reg.dry_limit};
            default:       prdata = '0;
        endcase
    end

    // The pipeline advances unless a finished result is held.
    assign en         = !(out_valid_reg && result_stall);
    assign item_stall = !en;

    erc_ln_path u_ln (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (item_valid),
        .in_mode       (mode),
        .water_content (water_content),
        .cfg           (cfg_reg),
        .result        (ln_res)
    );

    erc_exp_path u_exp (
        .clk           (clk),
        .en            (en),
        .pressure_head (pressure_head),
        .cfg           (cfg_reg),
        .result        (exp_res)
    );

    // Delay the shorter exponential path to line up with the log path.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            exp_dly_reg[0] <= exp_res;
            for (int i = 1; i < EXP_PAD; i++)
                exp_dly_reg[i] <= exp_dly_reg[i-1];
        end
    end

    // Output register: select the result for the item's mode.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= ln_res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ln_res.mode)
            begin
                head_reg    <= '0;
                content_reg <= exp_dly_reg[EXP_PAD-1].content;
                status_reg  <= exp_dly_reg[EXP_PAD-1].status;
            end
            else
            begin
                head_reg    <= ln_res.head;
                content_reg <= '0;
                status_reg  <= ln_res.status;
            end
        end
    end

    assign result_valid   = out_valid_reg;
    assign head_result    = head_reg;
    assign content_result = content_reg;
    assign status         = status_reg;

endmodule

// ----- src/erc_ln_path.sv -----
// ----------------------------------------------------------------------------
// Log path
// Head from water content: ratio division, log2 by repeated squaring, ln2
// scaling and division by the decay rate, one item per cycle while enabled.
// ----------------------------------------------------------------------------
module erc_ln_path (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic                in_mode,
    input  logic [15:0]         water_content,
    input  erc_pkg::cfg_t       cfg,
    output erc_pkg::ln_result_t result
);
    import erc_pkg::*;

    logic [15:0] den;
    logic [15:0] num_next;
    logic [15:0] num_reg;
    status_t     cls_next;
    tag_t        tag_reg [0:LN_LAT-1];

    logic [15:0] qrem_reg [0:QDIV_STAGES-1];
    logic [31:0] qquo_reg [0:QDIV_STAGES-1];
    logic [31:0] nm_next;
    logic [4:0]  np_next;
    logic [31:0] nm_reg;
    logic [4:0]  np_reg;
    logic [31:0] sqm_reg [0:SQ_STAGES-1];
    logic [31:0] sqf_reg [0:SQ_STAGES-1];
    logic [4:0]  sqp_reg [0:SQ_STAGES-1];
    logic [37:0] mag;
    logic [63:0] lnlo_prod;
    logic [37:0] lnhi_next;
    logic [37:0] lnhi_reg;
    logic [31:0] lnlo_reg;
    logic [37:0] lnmag_next;
    logic [37:0] lnmag_reg;
    logic [31:0] hrem_reg [0:HDIV_STAGES-1];
    logic [45:0] hdq_reg  [0:HDIV_STAGES-1];
    logic [47:0] head_next;
    logic [47:0] head_reg;

    // Classify the content and form the ratio operands.
    always_comb
    begin
        den      = cfg.saturated - cfg.residual;
        num_next = water_content - cfg.residual;
        priority if (water_content <= cfg.residual)
            cls_next = ST_DRY;
        else if (water_content >= cfg.saturated)
            cls_next = ST_DEGEN;
        else if (cfg.decay_rate == '0)
            cls_next = ST_SAT;
        else
            cls_next = ST_COMPUTED;
    end

    // Valid, mode and class travel down a shift line beside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LN_LAT; i++)
                tag_reg[i] <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= '{valid: in_valid, mode: in_mode, cls: cls_next};
            for (int i = 1; i < LN_LAT; i++)
                tag_reg[i] <= tag_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            num_reg <= num_next;
    end

    // Restoring division for floor(2^32 * num / den), four bits a stage.
    for (genvar g = 0; g < QDIV_STAGES; g++)
    begin : g_qdiv
        logic [15:0] rem_in;
        logic [31:0] quo_in;
        logic [15:0] rem_next;
        logic [31:0] quo_next;

        if (g == 0)
        begin : g_first
            assign rem_in = num_reg;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = qrem_reg[g-1];
            assign quo_in = qquo_reg[g-1];
        end

        always_comb
        begin
            logic [16:0] r;
            logic [31:0] q;
            r = {1'b0, rem_in};
            q = quo_in;
            for (int s = 0; s < QDIV_STEPS; s++)
            begin
                r = {r[15:0], 1'b0};
                if (r >= {1'b0, den})
                begin
                    r = r - {1'b0, den};
                    q = {q[30:0], 1'b1};
                end
                else
                begin
                    q = {q[30:0], 1'b0};
                end
            end
            rem_next = r[15:0];
            quo_next = q;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                qrem_reg[g] <= rem_next;
                qquo_reg[g] <= quo_next;
            end
        end
    end

    // Normalize the ratio so that its leading one sits at bit 31.
    always_comb
    begin
        logic [31:0] q;
        q       = qquo_reg[QDIV_STAGES-1];
        np_next = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (q[i])
                np_next = 5'(i);
        end
        nm_next = q << (~np_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_reg <= nm_next;
            np_reg <= np_next;
        end
    end

    // One squaring per stage yields one fraction bit of log2.
    for (genvar g = 0; g < SQ_STAGES; g++)
    begin : g_sq
        logic [31:0] m_in;
        logic [31:0] f_in;
        logic [4:0]  p_in;
        logic [31:0] m_next;
        logic [31:0] f_next;

        if (g == 0)
        begin : g_first
            assign m_in = nm_reg;
            assign f_in = '0;
            assign p_in = np_reg;
        end
        else
        begin : g_rest
            assign m_in = sqm_reg[g-1];
            assign f_in = sqf_reg[g-1];
            assign p_in = sqp_reg[g-1];
        end

        always_comb
        begin
            logic [63:0] sq;
            logic [32:0] s;
            sq = {32'd0, m_in} * {32'd0, m_in};
            s  = sq[63:31];
            if (s[32])
            begin
                m_next = s[32:1];
                f_next = {f_in[30:0], 1'b1};
            end
            else
            begin
                m_next = s[31:0];
                f_next = {f_in[30:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sqm_reg[g] <= m_next;
                sqf_reg[g] <= f_next;
                sqp_reg[g] <= p_in;
            end
        end
    end

    // Magnitude of log2 in Q6.32, then its two partial products with ln2.
    always_comb
    begin
        mag = {6'd32 - {1'b0, sqp_reg[SQ_STAGES-1]}, 32'd0}
            - {6'd0, sqf_reg[SQ_STAGES-1]};
        lnhi_next = {32'd0, mag[37:32]} * {6'd0, LN2_Q32};
        lnlo_prod = {32'd0, mag[31:0]} * {32'd0, LN2_Q32};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lnhi_reg <= lnhi_next;
            lnlo_reg <= lnlo_prod[63:32];
        end
    end

    // Sum the partial products into the natural log magnitude.
    assign lnmag_next = lnhi_reg + {6'd0, lnlo_reg};

    always_ff @(posedge clk)
    begin
        if (en)
            lnmag_reg <= lnmag_next;
    end

    // Restoring division of the scaled log by k, two quotient bits a stage.
    for (genvar g = 0; g < HDIV_STAGES; g++)
    begin : g_hdiv
        logic [31:0] rem_in;
        logic [45:0] dq_in;
        logic [31:0] rem_next;
        logic [45:0] dq_next;

        if (g == 0)
        begin : g_first
            assign rem_in = '0;
            assign dq_in  = {lnmag_reg, 8'd0};
        end
        else
        begin : g_rest
            assign rem_in = hrem_reg[g-1];
            assign dq_in  = hdq_reg[g-1];
        end

        always_comb
        begin
            logic [32:0] t;
            logic [31:0] r;
            logic [45:0] dq;
            r  = rem_in;
            dq = dq_in;
            for (int s = 0; s < HDIV_STEPS; s++)
            begin
                t  = {r, dq[45]};
                dq = {dq[44:0], 1'b0};
                if (t >= {1'b0, cfg.decay_rate})
                begin
                    t     = t - {1'b0, cfg.decay_rate};
                    dq[0] = 1'b1;
                end
                r = t[31:0];
            end
            rem_next = r;
            dq_next  = dq;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hrem_reg[g] <= rem_next;
                hdq_reg[g]  <= dq_next;
            end
        end
    end

    // Pick the head for the class of the item.
    always_comb
    begin
        unique case (tag_reg[LN_LAT-2].cls)
            ST_COMPUTED: head_next = 48'd0 - {2'b00, hdq_reg[HDIV_STAGES-1]};
            ST_DRY:      head_next = cfg.dry_limit;
            ST_SAT:      head_next = {1'b1, 47'd0};
            ST_DEGEN:    head_next = '0;
            default:     head_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            head_reg <= head_next;
    end

    assign result = '{valid:  tag_reg[LN_LAT-1].valid,
                      mode:   tag_reg[LN_LAT-1].mode,
                      status: tag_reg[LN_LAT-1].cls,
                      head:   head_reg};

endmodule

// ----- src/erc_exp_path.sv -----
// ----------------------------------------------------------------------------
// Exponential path
// Water content from head: k*h product, range reduction by ln2, series for
// the fractional exponential, scaling, rounding and clamping.
// ----------------------------------------------------------------------------
module erc_exp_path (
    input  logic                 clk,
    input  logic                 en,
    input  logic [47:0]          pressure_head,
    input  erc_pkg::cfg_t        cfg,
    output erc_pkg::exp_result_t result
);
    import erc_pkg::*;

    logic [47:0] a_next;
    logic [47:0] a_reg;
    logic        neg0_reg;
    logic [55:0] hi_next;
    logic [55:0] lo_next;
    logic [55:0] hi_reg;
    logic [55:0] lo_reg;
    logic        neg1_reg;
    logic [38:0] x_next;
    logic [38:0] x_reg;
    logic        neg2_reg;
    logic [38:0] xrem_reg [0:XDIV_STAGES-1];
    logic [6:0]  xq_reg   [0:XDIV_STAGES-1];
    logic        xneg_reg [0:XDIV_STAGES-1];
    logic [7:0]  sh_next;
    logic [31:0] r_next;
    logic [7:0]  sh_reg;
    logic [29:0] z_reg;
    logic [31:0] acc_reg [0:EXP_TERMS-1];
    logic [29:0] zc_reg  [0:EXP_TERMS-1];
    logic [7:0]  shc_reg [0:EXP_TERMS-1];
    logic        diff_neg;
    logic [15:0] diff_mag;
    logic [47:0] p_next;
    logic [47:0] p_reg;
    logic [7:0]  shp_reg;
    logic [37:0] term_next;
    logic [37:0] term_reg;
    exp_result_t res_next;
    exp_result_t res_reg;

    // Absolute value of the head.
    assign a_next = pressure_head[47] ? (~pressure_head + 48'd1) : pressure_head;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a_next;
            neg0_reg <= pressure_head[47];
        end
    end

    // k times the upper and lower halves of the head magnitude.
    assign hi_next = {24'd0, cfg.decay_rate} * {32'd0, a_reg[47:24]};
    assign lo_next = {24'd0, cfg.decay_rate} * {32'd0, a_reg[23:0]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
            neg1_reg <= neg0_reg;
        end
    end

    // Combine into |k*h| in Q.32 and cap at 64.0.
    always_comb
    begin
        logic [48:0] sum;
        sum = {11'd0, hi_reg[21:0], 16'd0} + {1'b0, lo_reg[55:8]};
        if (|hi_reg[55:22])
            x_next = XCAP_Q32;
        else if (sum > {10'd0, XCAP_Q32})
            x_next = XCAP_Q32;
        else
            x_next = sum[38:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            neg2_reg <= neg1_reg;
        end
    end

    // Division by ln2, one quotient bit a stage.
    for (genvar g = 0; g < XDIV_STAGES; g++)
    begin : g_xdiv
        localparam int BIT = XDIV_STAGES - 1 - g;
        localparam logic [38:0] STEP = {7'd0, LN2_Q32} << BIT;
        logic [38:0] rem_in;
        logic [6:0]  q_in;
        logic        neg_in;
        logic [38:0] rem_next;
        logic [6:0]  q_next;

        if (g == 0)
        begin : g_first
            assign rem_in = x_reg;
            assign q_in   = '0;
            assign neg_in = neg2_reg;
        end
        else
        begin : g_rest
            assign rem_in = xrem_reg[g-1];
            assign q_in   = xq_reg[g-1];
            assign neg_in = xneg_reg[g-1];
        end

        always_comb
        begin
            rem_next = rem_in;
            q_next   = q_in;
            if (rem_in >= STEP)
            begin
                rem_next    = rem_in - STEP;
                q_next[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                xrem_reg[g] <= rem_next;
                xq_reg[g]   <= q_next;
                xneg_reg[g] <= neg_in;
            end
        end
    end

    // Integer exponent as a right shift and the fractional remainder.
    always_comb
    begin
        logic [6:0]  q;
        logic [31:0] rem;
        q   = xq_reg[XDIV_STAGES-1];
        rem = xrem_reg[XDIV_STAGES-1][31:0];
        if (!xneg_reg[XDIV_STAGES-1])
        begin
            sh_next = SH_BASE - {1'b0, ((q > N_CAP) ? N_CAP : q)};
            r_next  = rem;
        end
        else if (rem == '0)
        begin
            sh_next = SH_BASE + {1'b0, q};
            r_next  = '0;
        end
        else
        begin
            sh_next = SH_BASE + {1'b0, q} + 8'd1;
            r_next  = LN2_Q32 - rem;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh_reg <= sh_next;
            z_reg  <= r_next[31:2];
        end
    end

    // Horner series for e^r: multiply, reciprocal divide, correct and add one.
    for (genvar g = 0; g < EXP_TERMS; g++)
    begin : g_term
        localparam int TERM = EXP_TERMS - g;
        logic [31:0] acc_in;
        logic [29:0] z_in;
        logic [7:0]  sh_in;
        logic [61:0] pa_reg;
        logic [29:0] za_reg;
        logic [7:0]  sha_reg;
        logic [31:0] tb_reg;
        logic [31:0] qb_next;
        logic [31:0] qb_reg;
        logic [29:0] zb_reg;
        logic [7:0]  shb_reg;
        logic [31:0] fix_next;
        logic [31:0] rem_c;

        if (g == 0)
        begin : g_first
            assign acc_in = ONE_Q30;
            assign z_in   = z_reg;
            assign sh_in  = sh_reg;
        end
        else
        begin : g_rest
            assign acc_in = acc_reg[g-1];
            assign z_in   = zc_reg[g-1];
            assign sh_in  = shc_reg[g-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pa_reg  <= {30'd0, acc_in} * {32'd0, z_in};
                za_reg  <= z_in;
                sha_reg <= sh_in;
            end
        end

        if (TERM == 1)
        begin : g_unit
            assign qb_next = pa_reg[61:30];
        end
        else
        begin : g_recip
            logic [63:0] qprod;
            assign qprod   = {32'd0, pa_reg[61:30]} * {32'd0, EXP_RECIP[TERM]};
            assign qb_next = qprod[63:32];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tb_reg  <= pa_reg[61:30];
                qb_reg  <= qb_next;
                zb_reg  <= za_reg;
                shb_reg <= sha_reg;
            end
        end

        // The reciprocal estimate is at most one low.
        always_comb
        begin
            rem_c = tb_reg - qb_reg * 32'(TERM);
            if (rem_c >= 32'(TERM))
                fix_next = ONE_Q30 + qb_reg + 32'd1;
            else
                fix_next = ONE_Q30 + qb_reg;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[g] <= fix_next;
                zc_reg[g]  <= zb_reg;
                shc_reg[g] <= shb_reg;
            end
        end
    end

    // Scale e^r by the content span.
    always_comb
    begin
        diff_neg = cfg.saturated < cfg.residual;
        diff_mag = diff_neg ? (cfg.residual - cfg.saturated)
                            : (cfg.saturated - cfg.residual);
        p_next   = {32'd0, diff_mag} * {16'd0, acc_reg[EXP_TERMS-1]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg   <= p_next;
            shp_reg <= shc_reg[EXP_TERMS-1];
        end
    end

    // Round half up while shifting down by 30 - n.
    always_comb
    begin
        logic [64:0] sum;
        logic [64:0] shifted;
        sum       = {17'd0, p_reg} + (65'd1 << (shp_reg[5:0] - 6'd1));
        shifted   = sum >> shp_reg[5:0];
        term_next = (shp_reg >= 8'd64) ? '0 : shifted[37:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            term_reg <= term_next;
    end

    // Offset by the residual content and clamp to the content range.
    always_comb
    begin
        logic [39:0] c;
        if (cfg.saturated < cfg.residual)
            c = {24'd0, cfg.residual} - {2'd0, term_reg};
        else
            c = {24'd0, cfg.residual} + {2'd0, term_reg};
        if (c[39])
            res_next = '{content: 16'd0, status: ST_DRY};
        else if (|c[38:16])
            res_next = '{content: 16'hFFFF, status: ST_SAT};
        else if (cfg.saturated <= cfg.residual)
            res_next = '{content: c[15:0], status: ST_DEGEN};
        else
            res_next = '{content: c[15:0], status: ST_COMPUTED};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign result = res_reg;

endmodule

// ----- src/erc_checker.sv -----
// ----------------------------------------------------------------------------
// Exponential retention curve port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "exponential_retention_curve_top_defines.svh"

module erc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [47:0] head_result,
    input logic [15:0] content_result,
    input logic [1:0]  status
);
    import erc_pkg::*;

    // A held result stays valid and its head stays unchanged.
    `ERC_ASSERT_NEXT(a_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(head_result))

    // Input is refused only while a finished result is held.
    `ERC_ASSERT_NOW(a_stall_cause, clk, rst_n, item_stall, result_valid && result_stall)

    // Only one of head and content carries a value.
    `ERC_ASSERT_NOW(a_one_field, clk, rst_n, result_valid && content_result != 16'd0, head_result == 48'd0)

    // A dry clamp never reports a nonzero content.
    `ERC_ASSERT_NOW(a_dry_zero, clk, rst_n, result_valid && status == ST_DRY, content_result == 16'd0)

endmodule

bind exponential_retention_curve_top erc_checker u_erc_checker (.*);

// ----- tb/tb_exponential_retention_curve_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exponential retention curve testbench
// Drives water contents and pressure heads through the block under random
// handshake pressure. A local fixed-point curve model predicts each result,
// and the result checker compares it field by field. The APB port is used
// to move the curve constants between phases.
// ----------------------------------------------------------------------------
module tb_exponential_retention_curve_top;
    import erc_pkg::*;

    localparam int PERIOD      = 8;
    localparam int DRAIN_WAIT  = 120;
    localparam int STALL_LIMIT = 20000;
    localparam logic [63:0] LN2_K  = 64'd2977044472;
    localparam logic [63:0] XCAP_K = 64'd1 << 38;
    localparam logic [63:0] ONE_K  = 64'd1 << 30;

    typedef struct {
        logic [47:0] head;
        logic [15:0] content;
        status_t     status;
    } curve_point_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        item_valid;
    logic        item_stall;
    logic        mode;
    logic [15:0] water_content;
    logic [47:0] pressure_head;
    logic        result_valid;
    logic        result_stall;
    logic [47:0] head_result;
    logic [15:0] content_result;
    logic [1:0]  status;

    // Local copy of the curve constants.
    logic [31:0] k_rate;
    logic [15:0] res_level;
    logic [15:0] sat_level;
    logic [47:0] h_dry;

    curve_point_t expected_points[$];
    int sender_idle_pct;
    int receiver_idle_pct;
    int fail_count;
    int quiet_cycles;

    exponential_retention_curve_top dut (.*);

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #(PERIOD / 2) clk = ~clk;
    end

    // Magnitude of ln(num/den) in Q.32.
    function automatic logic [63:0] ln_ratio_mag(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [63:0] t;
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] mag;
        int p;
        q = (num << 32) / den;
        t = q;
        p = 0;
        frac = 0;
        while (t > 1)
        begin
            t = t >> 1;
            p++;
        end
        m = q << (31 - p);
        for (int i = 0; i < 32; i++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32))
            begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        mag = (64'(32 - p) << 32) - frac;
        return (mag >> 32) * LN2_K + (((mag & 64'hFFFF_FFFF) * LN2_K) >> 32);
    endfunction

    // e^r in Q2.30 by a truncating series.
    function automatic logic [63:0] exp_series(logic [63:0] r);
        logic [63:0] z;
        logic [63:0] acc;
        z = r >> 2;
        acc = ONE_K;
        for (int n = 12; n >= 1; n--)
            acc = ONE_K + ((acc * z) >> 30) / n;
        return acc;
    endfunction

    // Predicted result for one item under the current constants.
    function automatic curve_point_t predict_curve(logic md, logic [15:0] th,
                                                   logic [47:0] hv);
        curve_point_t pt;
        logic [63:0] k;
        logic [63:0] a;
        logic [63:0] hi;
        logic [63:0] x;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] r;
        logic [63:0] p;
        logic [63:0] term;
        logic [63:0] mag;
        longint diff;
        longint c;
        int n;
        int sh;
        logic neg;
        pt.head = '0;
        pt.content = '0;
        pt.status = ST_COMPUTED;
        k = 64'(k_rate);
        if (!md)
        begin
            if (th <= res_level)
            begin
                pt.head = h_dry;
                pt.status = ST_DRY;
            end
            else if (th >= sat_level)
                pt.status = ST_DEGEN;
            else if (k == 0)
            begin
                pt.head = 48'h8000_0000_0000;
                pt.status = ST_SAT;
            end
            else
            begin
                mag = ln_ratio_mag(64'(th - res_level), 64'(sat_level - res_level));
                pt.head = 48'(64'd0 - ((mag << 8) / k));
            end
        end
        else
        begin
            neg = hv[47];
            a = neg ? 64'(48'(~hv + 48'd1)) : 64'(hv);
            hi = k * (a >> 24);
            if (hi >= (64'd1 << 22))
                x = XCAP_K;
            else
            begin
                x = (hi << 16) + ((k * (a & 64'hFF_FFFF)) >> 8);
                if (x > XCAP_K)
                    x = XCAP_K;
            end
            q = x / LN2_K;
            rem = x - q * LN2_K;
            if (!neg)
            begin
                n = int'(q);
                r = rem;
            end
            else if (rem == 0)
            begin
                n = -int'(q);
                r = 0;
            end
            else
            begin
                n = -int'(q + 1);
                r = LN2_K - rem;
            end
            if (n > 20)
                n = 20;
            diff = longint'(sat_level) - longint'(res_level);
            mag = 64'(diff < 0 ? -diff : diff);
            p = mag * exp_series(r);
            sh = 30 - n;
            term = (sh >= 64) ? 64'd0 : ((p + (64'd1 << (sh - 1))) >> sh);
            c = longint'(res_level) + (diff < 0 ? -longint'(term) : longint'(term));
            if (c < 0)
                pt.status = ST_DRY;
            else if (c > 65535)
            begin
                pt.content = 16'hFFFF;
                pt.status = ST_SAT;
            end
            else
            begin
                pt.content = 16'(c);
                pt.status = (sat_level <= res_level) ? ST_DEGEN : ST_COMPUTED;
            end
        end
        return pt;
    endfunction

    // Write one register over APB while the block is idle.
    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(8 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DECAY:     k_rate    = value[31:0];
            REG_RESIDUAL:  res_level = value[15:0];
            REG_SATURATED: sat_level = value[15:0];
            REG_DRY_LIMIT: h_dry     = value[47:0];
        endcase
    endtask

    task automatic set_curve(logic [31:0] k, logic [15:0] res, logic [15:0] sat,
                             logic [47:0] dry);
        write_reg(REG_DECAY, 64'(k));
        write_reg(REG_RESIDUAL, 64'(res));
        write_reg(REG_SATURATED, 64'(sat));
        write_reg(REG_DRY_LIMIT, 64'(dry));
    endtask

    // Send one transaction and record its prediction when accepted.
    // The valid line is dropped by the next idle cycle or by the drain.
    task automatic send_item(logic md, logic [15:0] th, logic [47:0] hv);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid    <= 1'b1;
        mode          <= md;
        water_content <= th;
        pressure_head <= hv;
        do @(posedge clk); while (item_stall);
        expected_points.push_back(predict_curve(md, th, hv));
    endtask

    // Let every expected result drain before touching the registers.
    task automatic wait_drained();
        item_valid <= 1'b0;
        wait (expected_points.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [47:0] random_head();
        case ($urandom_range(3))
            0: return 48'({$urandom, $urandom});
            1: return 48'(longint'($urandom_range(2000000)) - 1000000);
            2: return 48'(longint'($urandom_range(200000000)) - 100000000) << 4;
            default: return -48'($urandom_range(65536 * 200));
        endcase
    endfunction

    function automatic logic [15:0] random_content();
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(res_level > 0 ? res_level - 1 : 0,
                                  sat_level < 16'hFFFF ? sat_level + 1 : 16'hFFFF));
    endfunction

    // Edge cases under the reset constants and under extreme constants.
    task automatic test_directed();
        send_item(1'b0, 16'h0000, '0);
        send_item(1'b0, 16'hFFFF, '0);
        send_item(1'b0, 16'h0001, '0);
        send_item(1'b0, 16'h8000, '0);
        send_item(1'b0, 16'hFFFE, '0);
        send_item(1'b1, 16'hFFFF, 48'h0000_0000_0000);
        send_item(1'b1, 16'h0000, 48'h7FFF_FFFF_FFFF);
        send_item(1'b1, 16'h0000, 48'h8000_0000_0000);
        send_item(1'b1, 16'h0000, 48'hFFFF_FFFF_FFFF);
        send_item(1'b1, 16'h0000, 48'hFFFF_FFFF_0000);
        send_item(1'b1, 16'h0000, 48'h0000_0001_0000);
        wait_drained();
        // Zero decay rate in both modes, then an inverted curve.
        set_curve(32'h0, 16'd1000, 16'd50000, 48'h8000_0000_0000);
        send_item(1'b0, 16'd1000, '0);
        send_item(1'b0, 16'd20000, '0);
        send_item(1'b0, 16'd50000, '0);
        send_item(1'b1, 16'h0, 48'h8000_0000_0000);
        wait_drained();
        set_curve(32'hFFFF_FFFF, 16'd60000, 16'd100, 48'h0);
        send_item(1'b0, 16'd60001, '0);
        send_item(1'b0, 16'd200, '0);
        send_item(1'b1, 16'h0, 48'h0);
        send_item(1'b1, 16'h0, 48'hFFFF_FFFF_FFF0);
        send_item(1'b1, 16'h0, 48'h0000_0000_0100);
        wait_drained();
    endtask

    // Random items under one setting of the constants.
    task automatic test_random_phase(int count);
        for (int i = 0; i < count; i++)
            send_item(1'($urandom), random_content(), random_head());
        wait_drained();
    endtask

    task automatic test_random();
        logic [31:0] rates[4] = '{32'h0000_0001, 32'h0100_0000, 32'h0004_0000,
                                  32'hFFFF_FFFF};
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 3)
            begin
                sender_idle_pct   = 57;
                receiver_idle_pct = 27;
            end
            else if (ph == 6)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            set_curve(ph % 4 == 3 ? 32'($urandom) : rates[ph % 4],
                      16'($urandom_range(ph == 0 ? 0 : 20000)),
                      16'($urandom_range(ph == 0 ? 65535 : 30000, 65535)),
                      48'(-longint'({$urandom_range(32767), $urandom})));
            test_random_phase(50);
        end
    endtask

    // Receiver stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // Result checker and watchdog.
    always @(posedge clk)
    begin
        curve_point_t want;
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (result_valid && !result_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    $display("%0t: unexpected result head=%h content=%h status=%0d",
                             $time, head_result, content_result, status);
                    fail_count++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (head_result !== want.head)
                    begin
                        $display("%0t: head_result expected %h actual %h",
                                 $time, want.head, head_result);
                        fail_count++;
                    end
                    if (content_result !== want.content)
                    begin
                        $display("%0t: content_result expected %h actual %h",
                                 $time, want.content, content_result);
                        fail_count++;
                    end
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                        fail_count++;
                    end
                end
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_valid = 1'b0;
        mode = 1'b0;
        water_content = '0;
        pressure_head = '0;
        fail_count = 0;
        quiet_cycles = 0;
        sender_idle_pct = 27;
        receiver_idle_pct = 57;
        k_rate = DECAY_RESET;
        res_level = RESIDUAL_RESET;
        sat_level = SATURATED_RESET;
        h_dry = DRY_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+src
src/erc_pkg.sv
src/erc_ln_path.sv
src/erc_exp_path.sv
src/exponential_retention_curve_top.sv
src/erc_checker.sv
tb/tb_exponential_retention_curve_top.sv
